[rtl/banked_uart_register_block_core_defines.svh]
// Assertion helpers for the banked UART register block.
// Each macro clocks on clk and is disabled while rst is high.
`ifndef BANKED_UART_REGISTER_BLOCK_CORE_DEFINES_SVH
`define BANKED_UART_REGISTER_BLOCK_CORE_DEFINES_SVH

// Same-cycle implication
`define BUREG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bureg assertion failed");

// Next-cycle implication
`define BUREG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bureg assertion failed");

`endif

[rtl/bureg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bureg_pkg
// Types and fixed constants of the banked UART register block.
// ----------------------------------------------------------------------------
package bureg_pkg;

  // Access kinds
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RAISE = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Port offsets
  typedef enum logic [1:0] {
    PORT_DATA = 2'd0,
    PORT_LINE = 2'd1,
    PORT_MODEM = 2'd2,
    PORT_BANK = 2'd3
  } port_t;

  // Register banks
  typedef enum logic [1:0] {
    BANK_0 = 2'd0,
    BANK_1 = 2'd1,
    BANK_2 = 2'd2,
    BANK_3 = 2'd3
  } bank_t;

  localparam int unsigned VEC_W   = 5;
  localparam int unsigned VEC_NUM = 32;

  // Register masks and fixed read values
  localparam logic [7:0] BSR_MASK      = 8'hCF;
  localparam logic [7:0] FCR_MASK      = 8'hC8;
  localparam logic [7:0] LSR_TX_EMPTY  = 8'h60;
  localparam logic [7:0] LSR_RX_AVAIL  = 8'h01;
  localparam logic [7:0] MCR_RX_CLEAR  = 8'hEF;
  localparam logic [7:0] MCR_RX_SET    = 8'h10;
  localparam logic [7:0] BANK_WR_MASK  = 8'hFC;
  localparam logic [7:0] DATA_NONE     = 8'hFF;
  localparam logic [7:0] FCR_RD_TAG    = 8'h01;
  localparam logic [7:0] IER_RD_TAG    = 8'h02;
  localparam logic [7:0] BANK3_RD_VAL  = 8'h03;
  localparam int unsigned UART_EN_BIT  = 5;
  localparam int unsigned CLK_EN_BIT   = 2;

  // Access request
  typedef struct packed {
    mode_t       mode;
    port_t       port;
    logic [7:0]  wdata;
    logic [VEC_W-1:0] vector;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        tx_ready;
  } req_t;

  // Access result
  typedef struct packed {
    logic [7:0] rdata;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_take;
    logic       rx_flush;
  } rsp_t;

endpackage

[rtl/bureg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bureg_req_if / bureg_rsp_if
// Valid/ready channels for access requests and access results.
// ----------------------------------------------------------------------------
interface bureg_req_if;
  logic           valid;
  logic           ready;
  bureg_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bureg_rsp_if;
  logic           valid;
  logic           ready;
  bureg_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/banked_uart_register_block_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_uart_register_block_core
// Banked UART register file with host line pass-through and a pending
// interrupt vector set. One access per transfer, one result per access.
// ----------------------------------------------------------------------------
// Timing: the result reaches the output register in the cycle after the
//   request transfer; register updates apply to the very next request.
// Throughput: one access per cycle, set by the single decode/update stage;
//   a new request is taken whenever the output register is empty or drains.
// Reset: synchronous rst clears all registers, the bank select, the pending
//   vector set and the output valid flag.
module banked_uart_register_block_core #(
  parameter int unsigned NO_VECTOR = 31
) (
  input  logic               clk,
  input  logic               rst,
  bureg_req_if.sink          req,
  bureg_rsp_if.source        rsp
);

  // Lowest set bit: {found, index}, found through four byte groups
  function automatic logic [bureg_pkg::VEC_W:0] first_set(
    input logic [bureg_pkg::VEC_NUM-1:0] bits
  );
    logic [3:0] grp_any;
    logic [2:0] grp_idx [4];
    logic [bureg_pkg::VEC_W:0] res;
    for (int g = 0; g < 4; g++) begin
      grp_any[g] = |bits[g*8 +: 8];
      grp_idx[g] = 3'd0;
      for (int i = 7; i >= 0; i--) begin
        if (bits[g*8 + i]) begin
          grp_idx[g] = 3'(i);
        end
      end
    end
    res = '0;
    for (int g = 3; g >= 0; g--) begin
      if (grp_any[g]) begin
        res = {1'b1, 2'(g), grp_idx[g]};
      end
    end
    return res;
  endfunction

  localparam logic [bureg_pkg::VEC_W-1:0] NO_VEC = bureg_pkg::VEC_W'(NO_VECTOR);

  // Architectural registers
  bureg_pkg::bank_t bank_select, bank_select_next;
  logic [7:0] baud_select_reg, baud_select_reg_next;
  logic [7:0] char_stop_reg, char_stop_reg_next;
  logic [7:0] gpio_control_reg, gpio_control_reg_next;
  logic [7:0] line_control_reg, line_control_reg_next;
  logic [7:0] irda_control_reg, irda_control_reg_next;
  logic [7:0] char_start_reg, char_start_reg_next;
  logic [7:0] spare_reg, spare_reg_next;
  logic [7:0] modem_control_reg, modem_control_reg_next;
  logic [7:0] modem_status_reg, modem_status_reg_next;
  logic [7:0] mode_enable_reg, mode_enable_reg_next;
  logic [7:0] port_output_reg, port_output_reg_next;
  logic       clock_enable_bit, clock_enable_bit_next;
  logic [7:0] fifo_control_reg, fifo_control_reg_next;
  logic [7:0] int_enable_reg, int_enable_reg_next;
  logic [bureg_pkg::VEC_NUM-1:0] pending_vectors, pending_vectors_next;

  // Output register
  logic            out_valid;
  bureg_pkg::rsp_t out_data, rsp_next;

  logic                      acc;
  logic                      uart_en;
  logic                      rx_hit;
  logic [bureg_pkg::VEC_W:0] low_vec;
  logic [bureg_pkg::VEC_W-1:0] vec_rd;
  bureg_pkg::req_t           r;

  assign r       = req.data;
  assign req.ready = !out_valid || rsp.ready;
  assign acc     = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign uart_en = mode_enable_reg[bureg_pkg::UART_EN_BIT];
  assign rx_hit  = uart_en && r.rx_ready;
  assign low_vec = first_set(pending_vectors);
  assign vec_rd  = low_vec[bureg_pkg::VEC_W] ? low_vec[bureg_pkg::VEC_W-1:0] : NO_VEC;

  // Access decode and register update
  always_comb begin
    rsp_next               = '0;
    bank_select_next       = bank_select;
    baud_select_reg_next   = baud_select_reg;
    char_stop_reg_next     = char_stop_reg;
    gpio_control_reg_next  = gpio_control_reg;
    line_control_reg_next  = line_control_reg;
    irda_control_reg_next  = irda_control_reg;
    char_start_reg_next    = char_start_reg;
    spare_reg_next         = spare_reg;
    modem_control_reg_next = modem_control_reg;
    modem_status_reg_next  = modem_status_reg;
    mode_enable_reg_next   = mode_enable_reg;
    port_output_reg_next   = port_output_reg;
    clock_enable_bit_next  = clock_enable_bit;
    fifo_control_reg_next  = fifo_control_reg;
    int_enable_reg_next    = int_enable_reg;
    pending_vectors_next   = pending_vectors;

    unique case (r.mode)
      bureg_pkg::MODE_READ: begin
        unique case (r.port)
          bureg_pkg::PORT_DATA: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: begin
                if (rx_hit) begin
                  rsp_next.rdata   = r.rx_byte;
                  rsp_next.rx_take = 1'b1;
                end else begin
                  rsp_next.rdata = bureg_pkg::DATA_NONE;
                end
              end
              bureg_pkg::BANK_1: rsp_next.rdata = baud_select_reg;
              bureg_pkg::BANK_2: rsp_next.rdata = char_stop_reg;
              bureg_pkg::BANK_3: rsp_next.rdata = gpio_control_reg;
            endcase
          end
          bureg_pkg::PORT_LINE: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: begin
                rsp_next.rdata = (r.tx_ready ? bureg_pkg::LSR_TX_EMPTY : 8'h00)
                               | (rx_hit ? bureg_pkg::LSR_RX_AVAIL : 8'h00);
              end
              bureg_pkg::BANK_1: rsp_next.rdata = irda_control_reg;
              bureg_pkg::BANK_2: rsp_next.rdata = char_start_reg;
              bureg_pkg::BANK_3: rsp_next.rdata = spare_reg;
            endcase
          end
          bureg_pkg::PORT_MODEM: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: begin
                // bit 4 tracks live receive status and is written back into the register
                modem_control_reg_next = (modem_control_reg & bureg_pkg::MCR_RX_CLEAR)
                                       | (rx_hit ? bureg_pkg::MCR_RX_SET : 8'h00);
                rsp_next.rdata = modem_control_reg_next;
              end
              bureg_pkg::BANK_1: rsp_next.rdata = modem_status_reg;
              bureg_pkg::BANK_2: rsp_next.rdata = mode_enable_reg;
              bureg_pkg::BANK_3: rsp_next.rdata = port_output_reg;
            endcase
          end
          bureg_pkg::PORT_BANK: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: rsp_next.rdata = {vec_rd, clock_enable_bit, 2'b00};
              bureg_pkg::BANK_1: rsp_next.rdata = fifo_control_reg | bureg_pkg::FCR_RD_TAG;
              bureg_pkg::BANK_2: rsp_next.rdata = int_enable_reg | bureg_pkg::IER_RD_TAG;
              bureg_pkg::BANK_3: rsp_next.rdata = bureg_pkg::BANK3_RD_VAL;
            endcase
          end
        endcase
      end

      bureg_pkg::MODE_WRITE: begin
        unique case (r.port)
          bureg_pkg::PORT_DATA: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: begin
                if (uart_en && r.tx_ready) begin
                  rsp_next.tx_valid = 1'b1;
                  rsp_next.tx_byte  = r.wdata;
                end
              end
              bureg_pkg::BANK_1: baud_select_reg_next = r.wdata & bureg_pkg::BSR_MASK;
              bureg_pkg::BANK_2: char_stop_reg_next = r.wdata;
              bureg_pkg::BANK_3: gpio_control_reg_next = r.wdata;
            endcase
          end
          bureg_pkg::PORT_LINE: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: line_control_reg_next = r.wdata;
              bureg_pkg::BANK_1: irda_control_reg_next = r.wdata;
              bureg_pkg::BANK_2: char_start_reg_next = r.wdata;
              bureg_pkg::BANK_3: spare_reg_next = r.wdata;
            endcase
          end
          bureg_pkg::PORT_MODEM: begin
            unique case (bank_select)
              bureg_pkg::BANK_0: modem_control_reg_next = r.wdata;
              bureg_pkg::BANK_1: modem_status_reg_next = r.wdata;
              bureg_pkg::BANK_2: begin
                // flush on enable toggle or while disabled
                rsp_next.rx_flush = (uart_en != r.wdata[bureg_pkg::UART_EN_BIT])
                                  || !r.wdata[bureg_pkg::UART_EN_BIT];
                mode_enable_reg_next = r.wdata;
              end
              bureg_pkg::BANK_3: port_output_reg_next = r.wdata & gpio_control_reg;
            endcase
          end
          bureg_pkg::PORT_BANK: begin
            // old bank routes the upper bits, then the bank switches
            unique case (bank_select)
              bureg_pkg::BANK_0: clock_enable_bit_next = r.wdata[bureg_pkg::CLK_EN_BIT];
              bureg_pkg::BANK_1: fifo_control_reg_next = r.wdata & bureg_pkg::FCR_MASK;
              bureg_pkg::BANK_2: int_enable_reg_next = r.wdata & bureg_pkg::BANK_WR_MASK;
              bureg_pkg::BANK_3: ;
            endcase
            bank_select_next = bureg_pkg::bank_t'(r.wdata[1:0]);
          end
        endcase
      end

      bureg_pkg::MODE_RAISE: begin
        if (r.vector != NO_VEC) begin
          pending_vectors_next[r.vector] = 1'b1;
        end
      end

      bureg_pkg::MODE_CLEAR: begin
        if (r.vector != NO_VEC) begin
          pending_vectors_next[r.vector] = 1'b0;
        end
      end
    endcase
  end

  // Register state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select       <= bureg_pkg::BANK_0;
      baud_select_reg   <= '0;
      char_stop_reg     <= '0;
      gpio_control_reg  <= '0;
      line_control_reg  <= '0;
      irda_control_reg  <= '0;
      char_start_reg    <= '0;
      spare_reg         <= '0;
      modem_control_reg <= '0;
      modem_status_reg  <= '0;
      mode_enable_reg   <= '0;
      port_output_reg   <= '0;
      clock_enable_bit  <= 1'b0;
      fifo_control_reg  <= '0;
      int_enable_reg    <= '0;
      pending_vectors   <= '0;
    end else if (acc) begin
      bank_select       <= bank_select_next;
      baud_select_reg   <= baud_select_reg_next;
      char_stop_reg     <= char_stop_reg_next;
      gpio_control_reg  <= gpio_control_reg_next;
      line_control_reg  <= line_control_reg_next;
      irda_control_reg  <= irda_control_reg_next;
      char_start_reg    <= char_start_reg_next;
      spare_reg         <= spare_reg_next;
      modem_control_reg <= modem_control_reg_next;
      modem_status_reg  <= modem_status_reg_next;
      mode_enable_reg   <= mode_enable_reg_next;
      port_output_reg   <= port_output_reg_next;
      clock_enable_bit  <= clock_enable_bit_next;
      fifo_control_reg  <= fifo_control_reg_next;
      int_enable_reg    <= int_enable_reg_next;
      pending_vectors   <= pending_vectors_next;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data <= rsp_next;
    end
  end

endmodule

[rtl/bureg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bureg_checker
// Port-level checks of the banked UART register block, bound to the top.
// ----------------------------------------------------------------------------
`include "banked_uart_register_block_core_defines.svh"

module bureg_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input bureg_pkg::mode_t  req_mode,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bureg_pkg::rsp_t   rsp_data
);

  // stalled result holds
  `BUREG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // empty output register never blocks a request
  `BUREG_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready)

  // every request transfer yields a result next cycle
  `BUREG_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid)

  // only reads return data or consume a received byte
  `BUREG_ASSERT_NEXT(a_nonread_quiet,
    req_valid && req_ready && req_mode != bureg_pkg::MODE_READ,
    rsp_data.rdata == 8'h00 && !rsp_data.rx_take)

endmodule

bind banked_uart_register_block_core bureg_checker u_bureg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.data.mode),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
